>>> rtl/core/kqr_pkg.sv
// shared types, constants and the operation table of the keypoint refine unit
package kqr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NTAPS       = 19;
    localparam int TAP_W       = 5;
    localparam int SW          = SAMPLE_BITS + 5;      // hessian / gradient terms
    localparam int NSMALL      = 9;
    localparam int NWIDE       = 11;
    localparam int W           = 4 * SAMPLE_BITS + 20; // cofactors, det, adjugate rows, dot
    localparam int SEL_W       = 5;
    localparam int BSEL_W      = 4;
    localparam int WIX_W       = 4;
    localparam int DIG         = 7;                    // multiplier digit of the small operand
    localparam int NDIG        = (SW + DIG - 1) / DIG;
    localparam int KW          = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int NUOP        = 27;
    localparam int PC_W        = 5;

    localparam int OFF_W       = 16;
    localparam int VAL_W       = 21;
    localparam int OFF_SHIFT   = 13;
    localparam int VAL_SHIFT   = 3;
    localparam int OFF_QBITS   = 17;
    localparam int VAL_QBITS   = 42;
    localparam int QW          = VAL_QBITS + 1;
    localparam int DW          = W + VAL_QBITS + 1;
    localparam int CNT_W       = 6;
    localparam int QDEPTH      = 2;

    // operand codes: small terms first, then wide results
    localparam logic [SEL_W-1:0] R_HXX = 5'd0;
    localparam logic [SEL_W-1:0] R_HYY = 5'd1;
    localparam logic [SEL_W-1:0] R_HSS = 5'd2;
    localparam logic [SEL_W-1:0] R_HXY = 5'd3;
    localparam logic [SEL_W-1:0] R_HXS = 5'd4;
    localparam logic [SEL_W-1:0] R_HYS = 5'd5;
    localparam logic [SEL_W-1:0] R_GX  = 5'd6;
    localparam logic [SEL_W-1:0] R_GY  = 5'd7;
    localparam logic [SEL_W-1:0] R_GS  = 5'd8;
    localparam logic [SEL_W-1:0] R_AA  = 5'd9;
    localparam logic [SEL_W-1:0] R_AB  = 5'd10;
    localparam logic [SEL_W-1:0] R_AC  = 5'd11;
    localparam logic [SEL_W-1:0] R_BB  = 5'd12;
    localparam logic [SEL_W-1:0] R_BC  = 5'd13;
    localparam logic [SEL_W-1:0] R_CC  = 5'd14;
    localparam logic [SEL_W-1:0] R_DET = 5'd15;
    localparam logic [SEL_W-1:0] R_NR  = 5'd16;
    localparam logic [SEL_W-1:0] R_NC  = 5'd17;
    localparam logic [SEL_W-1:0] R_NS  = 5'd18;
    localparam logic [SEL_W-1:0] R_DOT = 5'd19;

    typedef struct packed {
        logic [NSMALL-1:0][SW-1:0] h;
        logic [SW-1:0]             c16;
        logic [11:0]               row;
        logic [11:0]               col;
        logic [2:0]                scale;
    } t_job;

    typedef struct packed {
        logic [SEL_W-1:0]  a;
        logic [SEL_W-1:0]  b;
        logic              sub;
        logic              first;
        logic              wr;
        logic [SEL_W-1:0]  dest;
    } t_uop;

    typedef struct packed {
        logic [OFF_W-1:0] offset_row;
        logic [OFF_W-1:0] offset_col;
        logic [OFF_W-1:0] offset_scale;
        logic [VAL_W-1:0] refined_value;
        logic             singular;
        logic [11:0]      key_row;
        logic [11:0]      key_col;
        logic [2:0]       key_scale;
    } t_result;

    function automatic logic [SW-1:0] sx(input logic [SAMPLE_BITS-1:0] v);
        return SW'($signed(v));
    endfunction

    function automatic t_uop mk(input logic [SEL_W-1:0] a, input logic [SEL_W-1:0] b,
                                input logic sub, input logic first, input logic wr,
                                input logic [SEL_W-1:0] dest);
        t_uop u;
        u.a = a; u.b = b; u.sub = sub; u.first = first; u.wr = wr; u.dest = dest;
        return u;
    endfunction

    // multiply-accumulate program: cofactors, det, -adj*g, g.n
    function automatic t_uop uop_at(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '0;
        case (pc)
            5'd0:  u = mk(R_HYY, R_HSS, 1'b0, 1'b1, 1'b0, R_AA);
            5'd1:  u = mk(R_HYS, R_HYS, 1'b1, 1'b0, 1'b1, R_AA);
            5'd2:  u = mk(R_HXS, R_HYS, 1'b0, 1'b1, 1'b0, R_AB);
            5'd3:  u = mk(R_HXY, R_HSS, 1'b1, 1'b0, 1'b1, R_AB);
            5'd4:  u = mk(R_HXY, R_HYS, 1'b0, 1'b1, 1'b0, R_AC);
            5'd5:  u = mk(R_HXS, R_HYY, 1'b1, 1'b0, 1'b1, R_AC);
            5'd6:  u = mk(R_HXX, R_HSS, 1'b0, 1'b1, 1'b0, R_BB);
            5'd7:  u = mk(R_HXS, R_HXS, 1'b1, 1'b0, 1'b1, R_BB);
            5'd8:  u = mk(R_HXY, R_HXS, 1'b0, 1'b1, 1'b0, R_BC);
            5'd9:  u = mk(R_HXX, R_HYS, 1'b1, 1'b0, 1'b1, R_BC);
            5'd10: u = mk(R_HXX, R_HYY, 1'b0, 1'b1, 1'b0, R_CC);
            5'd11: u = mk(R_HXY, R_HXY, 1'b1, 1'b0, 1'b1, R_CC);
            5'd12: u = mk(R_AA,  R_HXX, 1'b0, 1'b1, 1'b0, R_DET);
            5'd13: u = mk(R_AB,  R_HXY, 1'b0, 1'b0, 1'b0, R_DET);
            5'd14: u = mk(R_AC,  R_HXS, 1'b0, 1'b0, 1'b1, R_DET);
            5'd15: u = mk(R_AA,  R_GX,  1'b1, 1'b1, 1'b0, R_NR);
            5'd16: u = mk(R_AB,  R_GY,  1'b1, 1'b0, 1'b0, R_NR);
            5'd17: u = mk(R_AC,  R_GS,  1'b1, 1'b0, 1'b1, R_NR);
            5'd18: u = mk(R_AB,  R_GX,  1'b1, 1'b1, 1'b0, R_NC);
            5'd19: u = mk(R_BB,  R_GY,  1'b1, 1'b0, 1'b0, R_NC);
            5'd20: u = mk(R_BC,  R_GS,  1'b1, 1'b0, 1'b1, R_NC);
            5'd21: u = mk(R_AC,  R_GX,  1'b1, 1'b1, 1'b0, R_NS);
            5'd22: u = mk(R_BC,  R_GY,  1'b1, 1'b0, 1'b0, R_NS);
            5'd23: u = mk(R_CC,  R_GS,  1'b1, 1'b0, 1'b1, R_NS);
            5'd24: u = mk(R_NR,  R_GX,  1'b0, 1'b1, 1'b0, R_DOT);
            5'd25: u = mk(R_NC,  R_GY,  1'b0, 1'b0, 1'b0, R_DOT);
            5'd26: u = mk(R_NS,  R_GS,  1'b0, 1'b0, 1'b1, R_DOT);
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage

>>> rtl/core/kqr_front.sv
// front end: tap store, tag store and finite-difference terms of a finished keypoint
module kqr_front import kqr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [TAP_W-1:0]       i_tap,
    input  logic                   i_last_tap,
    input  logic [11:0]            i_at_row,
    input  logic [11:0]            i_at_col,
    input  logic [2:0]             i_at_scale,
    input  logic                   i_qfull,
    output logic                   o_full,
    output logic                   o_qpush,
    output t_job                   o_job
);

    logic [SAMPLE_BITS-1:0] r_tap [NTAPS];
    logic [11:0]            r_row, r_col;
    logic [2:0]             r_scale;
    logic                   r_pend;
    logic                   accept;
    logic [SW-1:0]          t [NTAPS];

    assign accept  = i_push && !r_pend;
    assign o_full  = r_pend;
    assign o_qpush = r_pend && !i_qfull;

    always_ff @(posedge i_clk) begin
        if (accept && (i_tap < TAP_W'(NTAPS))) begin
            r_tap[i_tap] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_scale <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (accept) begin
                r_row   <= i_at_row;
                r_col   <= i_at_col;
                r_scale <= i_at_scale;
            end
            if (accept && i_last_tap) begin
                r_pend <= 1'b1;
            end else if (o_qpush) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NTAPS; i++) begin
            t[i] = sx(r_tap[i]);
        end
        o_job.h[0] = (t[1] + t[2] - (t[0] << 1)) << 2;
        o_job.h[1] = (t[3] + t[4] - (t[0] << 1)) << 2;
        o_job.h[2] = (t[5] + t[6] - (t[0] << 1)) << 2;
        o_job.h[3] = (t[10] - t[9]) - (t[8] - t[7]);
        o_job.h[4] = (t[14] - t[13]) - (t[12] - t[11]);
        o_job.h[5] = (t[18] - t[17]) - (t[16] - t[15]);
        o_job.h[6] = t[2] - t[1];
        o_job.h[7] = t[4] - t[3];
        o_job.h[8] = t[6] - t[5];
        o_job.c16  = t[0] << 4;
        o_job.row  = r_row;
        o_job.col  = r_col;
        o_job.scale = r_scale;
    end

endmodule

>>> rtl/core/kqr_queue.sv
// short job queue between front end and solver
module kqr_queue import kqr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/kqr_divider.sv
// restoring divider with round to nearest and saturation, one quotient bit a cycle
module kqr_divider import kqr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic          i_wide,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_CHECK = 2'd1;
    localparam logic [1:0] D_RUN   = 2'd2;
    localparam logic [1:0] D_FIN   = 2'd3;

    localparam logic [QW-1:0] LIM_VAL = QW'(64'd1 << 40);
    localparam logic [QW-1:0] LIM_POS = QW'(32767);
    localparam logic [QW-1:0] LIM_NEG = QW'(32768);

    logic [1:0]       r_state;
    logic [DW-1:0]    r_rem, r_dsh;
    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg, r_wide, r_ovf, r_done;
    logic [QW-1:0]    r_quot;
    logic [W-1:0]     an, bn;
    logic [DW-1:0]    d1;
    logic [QW-1:0]    qf, lim, mag;

    assign an  = i_num[W-1] ? -i_num : i_num;
    assign bn  = i_den[W-1] ? -i_den : i_den;
    assign d1  = r_dsh >> 1;
    assign qf  = (r_q + 1'b1) >> 1;
    assign lim = r_wide ? LIM_VAL : (r_neg ? LIM_NEG : LIM_POS);
    assign mag = (r_ovf || (qf > lim)) ? lim : qf;

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_num[W-1] ^ i_den[W-1];
                        r_wide  <= i_wide;
                        r_rem   <= DW'({an, 1'b0});
                        r_dsh   <= DW'(bn) << (i_wide ? VAL_QBITS : OFF_QBITS);
                        r_cnt   <= i_wide ? CNT_W'(VAL_QBITS) : CNT_W'(OFF_QBITS);
                        r_q     <= '0;
                        r_state <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    // a quotient past the counted bits always clamps
                    r_ovf   <= (r_rem >= r_dsh);
                    r_state <= (r_rem >= r_dsh) ? D_FIN : D_RUN;
                end
                D_RUN: begin
                    if (r_rem >= d1) begin
                        r_rem <= r_rem - d1;
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_dsh <= d1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_quot  <= r_neg ? -mag : mag;
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/kqr_back.sv
// solver: digit-serial multiply-accumulate sequencer, divisions and result assembly
module kqr_back import kqr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_qempty,
    input  t_job    i_job,
    output logic    o_qpop,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_take
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAC    = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DWAIT  = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_HOLD   = 3'd5;

    localparam logic [1:0] DIX_VAL = 2'd3;

    localparam logic signed [QW:0] VMAX = (QW+1)'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
    localparam logic signed [QW:0] VMIN = (QW+1)'(-(64'sd1 <<< (VAL_W - 1)));

    logic [2:0]      r_state;
    t_job            r_job;
    logic [W-1:0]    r_w [NWIDE];
    logic [W-1:0]    r_det, r_acc;
    logic [PC_W-1:0] r_pc;
    logic [KW-1:0]   r_k;
    logic [1:0]      r_dix;
    logic            r_sing;
    logic [QW-1:0]   r_res [4];
    t_result         r_out;

    t_uop                   u;
    logic [SEL_W-1:0]       a_sel, div_sel, a_off, d_off;
    logic [W-1:0]           a_val, base, part, acc_n;
    logic [SW-1:0]          b_val;
    logic [NDIG*DIG-1:0]    b_ext;
    logic [DIG-1:0]         dig_raw;
    logic [DIG:0]           dig;
    logic signed [W+DIG:0]  prod;
    logic                   k_last;
    logic                   div_start, div_done;
    logic [W-1:0]           div_num;
    logic [QW-1:0]          div_quot;
    logic signed [QW:0]     vsum;

    assign u       = uop_at(r_pc);
    assign div_sel = (r_dix == DIX_VAL) ? R_DOT : R_NR + SEL_W'(r_dix);
    assign a_sel   = (r_state == S_MAC) ? u.a : div_sel;
    assign a_off   = a_sel - R_AA;
    assign d_off   = u.dest - R_AA;
    assign k_last  = (r_k == KW'(NDIG - 1));

    always_comb begin
        if (a_sel < R_AA) begin
            a_val = W'($signed(r_job.h[a_sel[BSEL_W-1:0]]));
        end else begin
            a_val = r_w[a_off[WIX_W-1:0]];
        end
        b_val   = r_job.h[u.b[BSEL_W-1:0]];
        b_ext   = (NDIG*DIG)'($signed(b_val));
        dig_raw = b_ext[r_k*DIG +: DIG];
        // top digit carries the sign of the small operand
        dig     = k_last ? {dig_raw[DIG-1], dig_raw} : {1'b0, dig_raw};
        prod    = $signed(a_val) * $signed(dig);
        part    = prod[W-1:0] << (r_k * DIG);
        base    = (u.first && (r_k == '0)) ? '0 : r_acc;
        acc_n   = u.sub ? base - part : base + part;
    end

    assign div_start = (r_state == S_DSTART) && (r_det != '0);
    assign div_num   = (r_dix == DIX_VAL) ? (a_val << VAL_SHIFT) : (a_val << OFF_SHIFT);

    kqr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_det),
        .i_wide  (r_dix == DIX_VAL),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign vsum = (r_sing ? '0 : (QW+1)'($signed(r_res[DIX_VAL])))
                + (QW+1)'($signed(r_job.c16));

    assign o_qpop  = (r_state == S_IDLE) && !i_qempty;
    assign o_valid = (r_state == S_HOLD);
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_qempty) begin
                        r_job   <= i_job;
                        r_pc    <= '0;
                        r_k     <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_acc <= acc_n;
                    if (k_last) begin
                        r_k <= '0;
                        if (u.wr) begin
                            r_w[d_off[WIX_W-1:0]] <= acc_n;
                            if (u.dest == R_DET) begin
                                r_det <= acc_n;
                            end
                        end
                        if (r_pc == PC_W'(NUOP - 1)) begin
                            r_dix   <= '0;
                            r_state <= S_DSTART;
                        end else begin
                            r_pc <= r_pc + 1'b1;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DSTART: begin
                    r_sing  <= (r_det == '0);
                    r_state <= (r_det == '0) ? S_FIN : S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_res[r_dix] <= div_quot;
                        if (r_dix == DIX_VAL) begin
                            r_state <= S_FIN;
                        end else begin
                            r_dix   <= r_dix + 1'b1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_FIN: begin
                    r_out.offset_row   <= r_sing ? '0 : r_res[0][OFF_W-1:0];
                    r_out.offset_col   <= r_sing ? '0 : r_res[1][OFF_W-1:0];
                    r_out.offset_scale <= r_sing ? '0 : r_res[2][OFF_W-1:0];
                    if (vsum > VMAX) begin
                        r_out.refined_value <= VMAX[VAL_W-1:0];
                    end else if (vsum < VMIN) begin
                        r_out.refined_value <= VMIN[VAL_W-1:0];
                    end else begin
                        r_out.refined_value <= vsum[VAL_W-1:0];
                    end
                    r_out.singular  <= r_sing;
                    r_out.key_row   <= r_job.row;
                    r_out.key_col   <= r_job.col;
                    r_out.key_scale <= r_job.scale;
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/keypoint_quadratic_refine_unit.sv
// top level of the sub-pixel keypoint refine unit
//
//  channel   direction  handshake          payload
//  sample    in         i_push / o_full    i_sample i_tap i_last_tap i_at_row i_at_col i_at_scale
//  result    out        o_empty / i_pop    o_offset_* o_refined_value o_singular o_key_*
//
// samples load at one item per cycle while o_full is low; the item with last_tap stalls
// input while its hessian terms move into a two-entry job queue, longer with the queue full
// the solver runs 27 multiply-accumulate steps on one shared digit-serial multiplier,
// then four bit-serial divisions (one for each offset and one for the value)
// loading of the next keypoint overlaps the solve; a finished result waits in the
// output register
// reset is synchronous and clears control and tags; the tap store is undefined until written
module keypoint_quadratic_refine_unit import kqr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [TAP_W-1:0]       i_tap,
    input  logic                   i_last_tap,
    input  logic [11:0]            i_at_row,
    input  logic [11:0]            i_at_col,
    input  logic [2:0]             i_at_scale,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [OFF_W-1:0]       o_offset_row,
    output logic [OFF_W-1:0]       o_offset_col,
    output logic [OFF_W-1:0]       o_offset_scale,
    output logic [VAL_W-1:0]       o_refined_value,
    output logic                   o_singular,
    output logic [11:0]            o_key_row,
    output logic [11:0]            o_key_col,
    output logic [2:0]             o_key_scale
);

    // front to queue
    logic    q_push, q_full, q_empty, q_pop;
    t_job    f_job, q_job;
    // solver to output register
    logic    b_valid, b_take;
    t_result b_res;
    logic    r_ovalid;
    t_result r_out;

    kqr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_sample   (i_sample),
        .i_tap      (i_tap),
        .i_last_tap (i_last_tap),
        .i_at_row   (i_at_row),
        .i_at_col   (i_at_col),
        .i_at_scale (i_at_scale),
        .i_qfull    (q_full),
        .o_full     (o_full),
        .o_qpush    (q_push),
        .o_job      (f_job)
    );

    kqr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    kqr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qempty (q_empty),
        .i_job    (q_job),
        .o_qpop   (q_pop),
        .o_valid  (b_valid),
        .o_res    (b_res),
        .i_take   (b_take)
    );

    // output register frees the solver as soon as the slot is free or being popped
    assign b_take = b_valid && (!r_ovalid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (b_take) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_take) begin
            r_out <= b_res;
        end
    end

    assign o_empty         = !r_ovalid;
    assign o_offset_row    = r_out.offset_row;
    assign o_offset_col    = r_out.offset_col;
    assign o_offset_scale  = r_out.offset_scale;
    assign o_refined_value = r_out.refined_value;
    assign o_singular      = r_out.singular;
    assign o_key_row       = r_out.key_row;
    assign o_key_col       = r_out.key_col;
    assign o_key_scale     = r_out.key_scale;

`ifndef SYNTHESIS
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && i_last_tap) |=> o_full)
        else $error("input not stalled after last item");

    a_back_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_valid && r_ovalid && !i_pop) |=> (b_valid && $stable(b_res)))
        else $error("solver result dropped while output register full");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("job pushed into full queue");
`endif

endmodule
